// ===== design/tmcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character codes
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [2:0] TAB_SPACES = 3'd4;

  // Register map (index = byte address / 4)
  localparam logic       REG_TEXT_COLOR   = 1'b0;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

  // Request kinds carried in tuser
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RADDR,
    S_RDATA,
    S_PUT,
    S_DONE
  } state_t;

  // Row map control from the sequencer
  typedef struct packed {
    logic       scroll;
    logic       mark;
    logic [7:0] color;
  } rowmap_ctl_t;

endpackage
`default_nettype wire

// ===== design/tmcw_rowmap.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmcw_rowmap #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  tmcw_pkg::rowmap_ctl_t        ctl,
  input  wire  [$clog2(ROWS)-1:0]      cur_row,
  input  wire  [$clog2(COLUMNS)-1:0]   cur_col,
  input  wire  [$clog2(ROWS)-1:0]      qry_row,
  input  wire  [$clog2(COLUMNS)-1:0]   qry_col,
  output logic [$clog2(ROWS)-1:0]      cur_phys,
  output logic [$clog2(ROWS)-1:0]      qry_phys,
  output logic                         qry_hit,
  output logic [7:0]                   qry_color
);
  import tmcw_pkg::*;

  localparam int RowW  = $clog2(ROWS);
  localparam int SumW  = RowW + 1;
  localparam int FillW = $clog2(COLUMNS + 1);

  // Physical row at the top of the screen; a scroll just advances it
  logic [RowW-1:0]  top;
  // Per physical row: cells below fill come from memory, the rest are blank
  logic [FillW-1:0] fill  [ROWS];
  logic [7:0]       color [ROWS];

  logic [SumW-1:0] cur_sum;
  logic [SumW-1:0] qry_sum;

  // Map logical rows to physical rows modulo ROWS
  always_comb begin
    cur_sum  = SumW'(top) + SumW'(cur_row);
    qry_sum  = SumW'(top) + SumW'(qry_row);
    cur_phys = (cur_sum >= SumW'(ROWS)) ? RowW'(cur_sum - SumW'(ROWS)) : RowW'(cur_sum);
    qry_phys = (qry_sum >= SumW'(ROWS)) ? RowW'(qry_sum - SumW'(ROWS)) : RowW'(qry_sum);
    qry_hit   = FillW'(qry_col) < fill[qry_phys];
    qry_color = color[qry_phys];
  end

  // Track fill marks and blank color per row; recycle the top row on scroll
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      for (int r = 0; r < ROWS; r++) begin
        fill[r]  <= '0;
        color[r] <= TEXT_COLOR_RESET;
      end
    end else begin
      if (ctl.mark) begin
        fill[cur_phys] <= FillW'(cur_col) + FillW'(1);
      end
      if (ctl.scroll) begin
        fill[top]  <= '0;
        color[top] <= ctl.color;
        top        <= (top == RowW'(ROWS - 1)) ? '0 : top + RowW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/text_mode_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Character-cell console of ROWS x COLUMNS 16-bit cells (attribute high byte,
// character low byte) kept in one synchronous RAM. Rows are addressed through
// a rotating top-row pointer, so a scroll costs no copy: the recycled row is
// marked blank with the current text color and reads as spaces until its
// cells are written again, in cursor order. No clearing pass is needed after
// reset. A request is taken only when the sequencer is idle; a put makes one
// RAM write, a tab one RAM write per space, a newline none, and a read goes
// through RAM address, registered read data and result. The result register
// lets the next request in while a result is still pending.
module text_mode_console_writer #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  wire         clk,
  input  wire         rst,
  // Request stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero
  input  wire  [0:0]  s_tuser,   // func[0]
  // Result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // cell_entry[15:0], cursor_row[20:16], cursor_col[27:21], zero
  // Configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmcw_pkg::*;

  localparam int RowW  = $clog2(ROWS);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int Depth = ROWS * COLUMNS;
  localparam int AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] ColsA = AddrW'(COLUMNS);

  state_t state, state_next;

  logic        func_q;
  logic [7:0]  ch_q;
  logic [4:0]  rrow_q;
  logic [6:0]  rcol_q;
  logic [2:0]  reps;
  logic [RowW-1:0] cur_row;
  logic [ColW-1:0] cur_col;
  logic [15:0] entry;
  logic        rd_inrange;
  logic        rd_hit;
  logic [7:0]  rd_color;
  logic [7:0]  text_color;

  logic [15:0] mem [Depth];
  logic [15:0] mem_q;
  logic [AddrW-1:0] mem_raddr;
  logic [AddrW-1:0] mem_waddr;
  logic        mem_we;
  logic [15:0] mem_wdata;

  rowmap_ctl_t      rm_ctl;
  logic [RowW-1:0]  cur_phys;
  logic [RowW-1:0]  qry_phys;
  logic             qry_hit;
  logic [7:0]       qry_color;

  logic s_acc;
  logic is_nl;
  logic at_eol;
  logic at_bottom;
  logic wrap;
  logic out_free;
  logic inrange;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'b0, text_color} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end

  // Row map
  tmcw_rowmap #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_rowmap (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rm_ctl),
    .cur_row   (cur_row),
    .cur_col   (cur_col),
    .qry_row   (RowW'(rrow_q)),
    .qry_col   (ColW'(rcol_q)),
    .cur_phys  (cur_phys),
    .qry_phys  (qry_phys),
    .qry_hit   (qry_hit),
    .qry_color (qry_color)
  );

  // Cursor advance and sequencer
  always_comb begin
    s_acc     = s_tvalid && s_tready;
    is_nl     = (ch_q == CH_NEWLINE);
    at_eol    = (cur_col == ColW'(COLUMNS - 1));
    at_bottom = (cur_row == RowW'(ROWS - 1));
    wrap      = is_nl || at_eol;
    out_free  = !m_tvalid || m_tready;
    inrange   = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);
    s_tready  = (state == S_IDLE);

    mem_raddr = AddrW'(qry_phys) * ColsA + AddrW'(ColW'(rcol_q));
    mem_waddr = AddrW'(cur_phys) * ColsA + AddrW'(cur_col);
    mem_we    = (state == S_PUT) && !is_nl;
    mem_wdata = {text_color, (ch_q == CH_TAB) ? CH_SPACE : ch_q};

    rm_ctl.mark   = mem_we;
    rm_ctl.scroll = (state == S_PUT) && wrap && at_bottom;
    rm_ctl.color  = text_color;

    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_acc) state_next = (s_tuser[0] == FUNC_READ) ? S_RADDR : S_PUT;
      end
      S_RADDR: state_next = S_RDATA;
      S_RDATA: state_next = S_DONE;
      S_PUT: begin
        if (is_nl || reps == 3'd1) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Screen RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (s_acc) begin
      func_q <= s_tuser[0];
      ch_q   <= s_tdata[7:0];
      rrow_q <= s_tdata[12:8];
      rcol_q <= s_tdata[19:13];
      reps   <= (s_tdata[7:0] == CH_TAB) ? TAB_SPACES : 3'd1;
    end else if (state == S_PUT) begin
      reps <= reps - 3'd1;
    end
  end

  // Hold read qualifiers, then form the cell
  always_ff @(posedge clk) begin
    if (state == S_RADDR) begin
      rd_inrange <= inrange;
      rd_hit     <= qry_hit;
      rd_color   <= qry_color;
    end
    if (s_acc) begin
      entry <= 16'd0;
    end else if (state == S_RDATA) begin
      if (!rd_inrange)  entry <= 16'd0;
      else if (rd_hit)  entry <= mem_q;
      else              entry <= {rd_color, CH_SPACE};
    end
  end

  // Move the cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (state == S_PUT) begin
      cur_col <= wrap ? '0 : cur_col + ColW'(1);
      if (wrap && !at_bottom) cur_row <= cur_row + RowW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {4'b0, 7'(cur_col), 5'(cur_row), entry};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> state != S_IDLE)
    else $error("sequencer stayed idle after a request");

  a_write_only_on_put: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_PUT && func_q == FUNC_PUT && ch_q != CH_NEWLINE))
    else $error("screen write outside a put");

  a_scroll_stays_bottom: assert property (@(posedge clk) disable iff (rst)
    rm_ctl.scroll |=> cur_row == RowW'(ROWS - 1))
    else $error("cursor left the bottom row after a scroll");

  a_done_loads_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("result not loaded on completion");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import tmcw_pkg::*;

  localparam int CELL_COUNT = DEF_ROWS * DEF_COLUMNS;

  typedef struct {
    logic       func;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } console_req_t;

  typedef struct {
    logic [15:0] entry;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [23:0] s_tdata = '0;   // char_code[7:0], read_row[12:8], read_col[19:13], zero
  logic [0:0]  s_tuser = '0;   // func[0]
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [31:0] m_tdata;        // cell_entry[15:0], cursor_row[20:16], cursor_col[27:21], zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  text_mode_console_writer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Console shadow state
  logic [15:0]     screen_model [CELL_COUNT];
  int unsigned     cur_line;
  int unsigned     cur_column;
  logic [7:0]      color_model;

  console_req_t    pending_req [$];
  console_result_t expected_res [$];
  console_req_t    in_flight;
  int              mismatches = 0;
  bit              idle_en = 1'b1;
  int              gap_left = 0;
  int              stall_left = 0;

  initial forever #4 clk = ~clk;

  // Move rows up one and blank the bottom row once the cursor falls off the screen
  function automatic void scroll_check();
    if (cur_line >= DEF_ROWS) begin
      for (int i = 0; i < (DEF_ROWS - 1) * DEF_COLUMNS; i++)
        screen_model[i] = screen_model[i + DEF_COLUMNS];
      for (int x = 0; x < DEF_COLUMNS; x++)
        screen_model[(DEF_ROWS - 1) * DEF_COLUMNS + x] = {color_model, CH_SPACE};
      cur_line = DEF_ROWS - 1;
    end
  endfunction

  // Write one cell at the cursor and advance with wrap
  function automatic void write_cell(logic [7:0] ch);
    screen_model[cur_line * DEF_COLUMNS + cur_column] = {color_model, ch};
    cur_column++;
    if (cur_column >= DEF_COLUMNS) begin
      cur_column = 0;
      cur_line++;
    end
    scroll_check();
  endfunction

  function automatic console_result_t predict_console(console_req_t req);
    console_result_t res;
    res.entry = '0;
    if (req.func == FUNC_READ) begin
      if (req.row < DEF_ROWS && req.col < DEF_COLUMNS)
        res.entry = screen_model[req.row * DEF_COLUMNS + req.col];
    end else if (req.ch == CH_TAB) begin
      for (int k = 0; k < TAB_SPACES; k++)
        write_cell(CH_SPACE);
    end else if (req.ch == CH_NEWLINE) begin
      cur_column = 0;
      cur_line++;
      scroll_check();
    end else begin
      write_cell(req.ch);
    end
    res.row = cur_line[4:0];
    res.col = cur_column[6:0];
    return res;
  endfunction

  function automatic void queue_req(logic func, logic [7:0] ch, logic [4:0] row,
                                    logic [6:0] col);
    console_req_t req;
    req.func = func;
    req.ch   = ch;
    req.row  = row;
    req.col  = col;
    pending_req.push_back(req);
  endfunction

  // Mostly text with newlines and tabs; reads lean toward the bottom row
  function automatic void queue_random_req();
    int          pick;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [6:0]  col;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 6) == 0) begin
        row = 5'($urandom_range(0, 31));
        col = 7'($urandom_range(0, 127));
      end else begin
        row = ($urandom_range(0, 2) == 0) ? 5'(DEF_ROWS - 1)
                                          : 5'($urandom_range(0, DEF_ROWS - 1));
        col = 7'($urandom_range(0, DEF_COLUMNS - 1));
      end
      queue_req(FUNC_READ, 8'($urandom_range(0, 255)), row, col);
    end else begin
      if (pick < 40)
        ch = CH_NEWLINE;
      else if (pick < 48)
        ch = CH_TAB;
      else if (pick < 60)
        ch = 8'($urandom_range(0, 255));
      else
        ch = 8'($urandom_range(32, 126));
      queue_req(FUNC_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    else if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver: account for the accepted request, then present the next one
  always @(posedge clk) begin
    bit slot_free;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      slot_free = !s_tvalid || s_tready;
      if (s_tvalid && s_tready)
        expected_res.push_back(predict_console(in_flight));
      if (slot_free) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_req.size() > 0) begin
          in_flight = pending_req.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {4'b0, in_flight.col, in_flight.row, in_flight.ch};
          s_tuser   <= in_flight.func;
          gap_left  <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expectation, stall at random
  always @(posedge clk) begin
    console_result_t exp_res;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h", m_tdata);
        end else begin
          exp_res = expected_res.pop_front();
          if (m_tdata[15:0] !== exp_res.entry || m_tdata[20:16] !== exp_res.row ||
              m_tdata[27:21] !== exp_res.col) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: cell %h row %0d col %0d, expected cell %h row %0d col %0d",
                       m_tdata[15:0], m_tdata[20:16], m_tdata[27:21],
                       exp_res.entry, exp_res.row, exp_res.col);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          stall_left <= pick_gap();
      end
    end
  end

  task automatic write_color(logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_TEXT_COLOR, 2'b00};
    pwdata  <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    color_model = value;
  endtask

  // Hold until every request is out and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_req.size() > 0 || s_tvalid || expected_res.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    logic [7:0] phase_color [5];
    for (int i = 0; i < CELL_COUNT; i++)
      screen_model[i] = {TEXT_COLOR_RESET, CH_SPACE};
    cur_line    = 0;
    cur_column  = 0;
    color_model = TEXT_COLOR_RESET;
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = 8'($urandom_range(0, 255));
    phase_color[3] = 8'($urandom_range(0, 255));
    phase_color[4] = 8'h5A;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: corner and out-of-range reads, extreme codes, tab and newline
    queue_req(FUNC_READ, 8'hFF, 5'd0, 7'd0);
    queue_req(FUNC_READ, 8'h00, 5'(DEF_ROWS - 1), 7'(DEF_COLUMNS - 1));
    queue_req(FUNC_READ, 8'h00, 5'd31, 7'd127);
    queue_req(FUNC_READ, 8'h00, 5'(DEF_ROWS), 7'd0);
    queue_req(FUNC_READ, 8'h00, 5'd0, 7'(DEF_COLUMNS));
    queue_req(FUNC_PUT, 8'h00, 5'd31, 7'd127);
    queue_req(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
    queue_req(FUNC_PUT, 8'h41, 5'd0, 7'd0);
    queue_req(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
    queue_req(FUNC_READ, 8'h00, 5'd0, 7'd0);
    queue_req(FUNC_READ, 8'h00, 5'd0, 7'd1);
    queue_req(FUNC_READ, 8'h00, 5'd0, 7'd4);
    queue_req(FUNC_PUT, CH_NEWLINE, 5'd0, 7'd0);
    queue_req(FUNC_PUT, CH_NEWLINE, 5'd0, 7'd0);
    queue_req(FUNC_PUT, 8'h7E, 5'd0, 7'd0);
    queue_req(FUNC_READ, 8'h00, 5'd2, 7'd0);
    drain();

    // Random phases under different colors; the middle phase runs without idling
    for (int p = 0; p < 5; p++) begin
      write_color(phase_color[p]);
      idle_en = (p != 2);
      for (int n = 0; n < 380; n++)
        queue_random_req();
      drain();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
